>>> rtl/core/srt_pkg.sv
// ----------------------------------------------------------------------------
// srt_pkg
// Shared types, constants and helpers of the sorted record table.
// ----------------------------------------------------------------------------
package srt_pkg;

    localparam int CAPACITY   = 16;
    localparam int ADDR_W     = 4;
    localparam int CNT_W      = 5;
    localparam int NAME_WORDS = 7;

    localparam logic [CNT_W-1:0] RESET_MAX_ENTRIES = 5'd10;
    localparam logic [CNT_W-1:0] CAPACITY_CNT      = 5'd16;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_LIST   = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_REMOVED   = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_ENTRY     = 3'd4;
    localparam logic [2:0] ST_EMPTY     = 3'd5;
    localparam logic [2:0] ST_CLEARED   = 3'd6;

    typedef logic [NAME_WORDS-1:0][55:0] name_t;

    typedef struct packed {
        logic signed [31:0] key;
        logic [7:0]         age;
        name_t              name;
    } rec_t;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] record_key;
        logic [7:0]         record_age;
        logic [55:0]        name_part0;
        logic [55:0]        name_part1;
        logic [55:0]        name_part2;
        logic [55:0]        name_part3;
        logic [55:0]        name_part4;
        logic [55:0]        name_part5;
        logic [55:0]        name_part6;
    } cmd_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] out_key;
        logic [7:0]         out_age;
        logic [55:0]        out_name0;
        logic [55:0]        out_name1;
        logic [55:0]        out_name2;
        logic [55:0]        out_name3;
        logic [55:0]        out_name4;
        logic [55:0]        out_name5;
        logic [55:0]        out_name6;
        logic [CNT_W-1:0]   entry_count;
        logic               last_result;
    } result_t;

    typedef struct packed {
        logic              re;
        logic [ADDR_W-1:0] raddr;
        logic              we;
        logic [ADDR_W-1:0] waddr;
        rec_t              wdata;
    } mem_req_t;

    // The name is a zero-terminated string: every byte after the first zero
    // byte is stored as zero.
    function automatic rec_t make_record(cmd_t c);
        name_t      parts;
        name_t      kept;
        logic       ended;
        logic [7:0] b;
        rec_t       r;
        parts = {c.name_part6, c.name_part5, c.name_part4, c.name_part3,
                 c.name_part2, c.name_part1, c.name_part0};
        ended = 1'b0;
        kept  = '0;
        for (int w = 0; w < NAME_WORDS; w++) begin
            for (int k = 0; k < 7; k++) begin
                b = parts[w][8*k +: 8];
                if (b == 8'h00) begin
                    ended = 1'b1;
                end
                kept[w][8*k +: 8] = ended ? 8'h00 : b;
            end
        end
        r.key  = c.record_key;
        r.age  = c.record_age;
        r.name = kept;
        return r;
    endfunction

    function automatic result_t status_result(logic [2:0] st, logic [CNT_W-1:0] cnt);
        result_t r;
        r             = '0;
        r.status      = st;
        r.entry_count = cnt;
        r.last_result = 1'b1;
        return r;
    endfunction

    function automatic result_t entry_result(rec_t e, logic [CNT_W-1:0] cnt, logic last);
        result_t r;
        r             = '0;
        r.status      = ST_ENTRY;
        r.out_key     = e.key;
        r.out_age     = e.age;
        r.out_name0   = e.name[0];
        r.out_name1   = e.name[1];
        r.out_name2   = e.name[2];
        r.out_name3   = e.name[3];
        r.out_name4   = e.name[4];
        r.out_name5   = e.name[5];
        r.out_name6   = e.name[6];
        r.entry_count = cnt;
        r.last_result = last;
        return r;
    endfunction

endpackage

>>> rtl/core/sorted_record_table.sv
// ----------------------------------------------------------------------------
// sorted_record_table
// Bounded table of records kept in ascending signed key order, with insert,
// delete by key, list and clear commands.
// ----------------------------------------------------------------------------
//  channel   signals                        transfer when
//  -------   -----------------------------  ----------------------------------
//  command   start, busy, cmd               start high and busy low
//  result    result_valid, result           result_valid high
//  config    cfg_valid, cfg_ready, cfg_data cfg_valid and cfg_ready high
//
// Records sit in one RAM, scanned one entry per cycle. Full, empty, clear
// and an insert into an empty table need no scan; any other insert walks
// down from the top entry to its place, and delete and list scan every
// entry (one list result per cycle). Results are registered and appear in the
// cycle after they are produced. Reset clears the count and sets max_entries
// to 10, not the RAM. The receiver cannot stall the result channel.
// ----------------------------------------------------------------------------
module sorted_record_table (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  srt_pkg::cmd_t             cmd,
    output logic                      result_valid,
    output srt_pkg::result_t          result,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [srt_pkg::CNT_W-1:0] cfg_data
);

    logic [srt_pkg::CNT_W-1:0] max_entries_reg;
    logic                      result_valid_reg;
    srt_pkg::result_t          result_reg;

    srt_pkg::mem_req_t         mem_req;
    srt_pkg::rec_t             mem_rdata;
    logic                      res_valid;
    srt_pkg::result_t          res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_entries_reg  <= srt_pkg::RESET_MAX_ENTRIES;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                max_entries_reg <= cfg_data;
            end
            result_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            result_reg <= res;
        end
    end

    srt_record_ram u_ram (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    srt_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .cmd         (cmd),
        .max_entries (max_entries_reg),
        .busy        (busy),
        .mem_req     (mem_req),
        .mem_rdata   (mem_rdata),
        .res_valid   (res_valid),
        .res         (res)
    );

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

>>> rtl/core/srt_record_ram.sv
// ----------------------------------------------------------------------------
// srt_record_ram
// Record store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module srt_record_ram (
    input  logic             clk,
    input  srt_pkg::mem_req_t req,
    output srt_pkg::rec_t    rdata
);

    srt_pkg::rec_t mem [srt_pkg::CAPACITY];
    srt_pkg::rec_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/srt_seq.sv
// ----------------------------------------------------------------------------
// srt_seq
// Operation sequencer: scans the record store one entry per cycle, shifting
// records up on insert and down on delete, and streams the list.
// ----------------------------------------------------------------------------
module srt_seq (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  srt_pkg::cmd_t              cmd,
    input  logic [srt_pkg::CNT_W-1:0]  max_entries,
    output logic                       busy,
    output srt_pkg::mem_req_t          mem_req,
    input  srt_pkg::rec_t              mem_rdata,
    output logic                       res_valid,
    output srt_pkg::result_t           res
);

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_INS     = 5'b00010,
        S_INS_PUT = 5'b00100,
        S_DEL     = 5'b01000,
        S_LIST    = 5'b10000
    } state_t;

    state_t                       state_reg, state_next;
    logic [srt_pkg::ADDR_W-1:0]   idx_reg, idx_next;
    logic [srt_pkg::CNT_W-1:0]    count_reg, count_next;
    logic                         found_reg, found_next;
    srt_pkg::rec_t                pend_reg, pend_next;

    logic [srt_pkg::CNT_W-1:0]    limit;
    logic [srt_pkg::CNT_W-1:0]    count_dec;
    logic [srt_pkg::ADDR_W-1:0]   top_addr;
    logic                         at_last;
    logic                         key_match;

    assign limit     = (max_entries > srt_pkg::CAPACITY_CNT) ? srt_pkg::CAPACITY_CNT
                                                             : max_entries;
    assign count_dec = count_reg - 5'd1;
    assign top_addr  = count_dec[srt_pkg::ADDR_W-1:0];
    assign at_last   = ({1'b0, idx_reg} == count_dec);
    assign key_match = (mem_rdata.key == pend_reg.key);
    assign busy      = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        found_next = found_reg;
        pend_next  = pend_reg;
        mem_req    = '0;
        res_valid  = 1'b0;
        res        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    pend_next = srt_pkg::make_record(cmd);
                    unique case (cmd.operation)
                        srt_pkg::OP_INSERT:
                        begin
                            if (count_reg >= limit)
                            begin
                                res_valid = 1'b1;
                                res = srt_pkg::status_result(srt_pkg::ST_FULL, count_reg);
                            end
                            else if (count_reg == '0)
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = '0;
                                mem_req.wdata = srt_pkg::make_record(cmd);
                                count_next    = 5'd1;
                                res_valid     = 1'b1;
                                res = srt_pkg::status_result(srt_pkg::ST_INSERTED, 5'd1);
                            end
                            else
                            begin
                                // Walk down from the top entry, moving larger and equal keys up.
                                mem_req.re    = 1'b1;
                                mem_req.raddr = top_addr;
                                idx_next      = top_addr;
                                state_next    = S_INS;
                            end
                        end
                        srt_pkg::OP_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_valid = 1'b1;
                                res = srt_pkg::status_result(srt_pkg::ST_NOT_FOUND, count_reg);
                            end
                            else
                            begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = '0;
                                idx_next      = '0;
                                found_next    = 1'b0;
                                state_next    = S_DEL;
                            end
                        end
                        srt_pkg::OP_LIST:
                        begin
                            if (count_reg == '0)
                            begin
                                res_valid = 1'b1;
                                res = srt_pkg::status_result(srt_pkg::ST_EMPTY, count_reg);
                            end
                            else
                            begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = '0;
                                idx_next      = '0;
                                state_next    = S_LIST;
                            end
                        end
                        srt_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                            res_valid  = 1'b1;
                            res = srt_pkg::status_result(srt_pkg::ST_CLEARED, 5'd0);
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // mem_rdata holds entry idx_reg.
            S_INS:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = idx_reg + 4'd1;
                if (mem_rdata.key < pend_reg.key)
                begin
                    mem_req.wdata = pend_reg;
                    count_next    = count_reg + 5'd1;
                    res_valid     = 1'b1;
                    res = srt_pkg::status_result(srt_pkg::ST_INSERTED, count_reg + 5'd1);
                    state_next    = S_IDLE;
                end
                else
                begin
                    mem_req.wdata = mem_rdata;
                    if (idx_reg == '0)
                    begin
                        state_next = S_INS_PUT;
                    end
                    else
                    begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = idx_reg - 4'd1;
                        idx_next      = idx_reg - 4'd1;
                    end
                end
            end

            S_INS_PUT:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = '0;
                mem_req.wdata = pend_reg;
                count_next    = count_reg + 5'd1;
                res_valid     = 1'b1;
                res = srt_pkg::status_result(srt_pkg::ST_INSERTED, count_reg + 5'd1);
                state_next    = S_IDLE;
            end

            // Once the match is seen, every later entry moves down one slot.
            S_DEL:
            begin
                if (found_reg)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = idx_reg - 4'd1;
                    mem_req.wdata = mem_rdata;
                end
                else if (key_match)
                begin
                    found_next = 1'b1;
                end
                if (at_last)
                begin
                    res_valid  = 1'b1;
                    state_next = S_IDLE;
                    if (found_reg || key_match)
                    begin
                        count_next = count_dec;
                        res = srt_pkg::status_result(srt_pkg::ST_REMOVED, count_dec);
                    end
                    else
                    begin
                        res = srt_pkg::status_result(srt_pkg::ST_NOT_FOUND, count_reg);
                    end
                end
                else
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = idx_reg + 4'd1;
                    idx_next      = idx_reg + 4'd1;
                end
            end

            S_LIST:
            begin
                res_valid = 1'b1;
                res = srt_pkg::entry_result(mem_rdata, count_reg, at_last);
                if (at_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = idx_reg + 4'd1;
                    idx_next      = idx_reg + 4'd1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            count_reg <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            count_reg <= count_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

endmodule

>>> test/tb_sorted_record_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_record_table
// Self-checking bench for the sorted record table. A short table of directed
// commands covers the empty, full and not-found cases, equal and extreme keys,
// name termination and limit changes. Random phases then run under several
// table limits. Every accepted command is run through a local model of the
// table, and each result transfer is compared field by field with the oldest
// pending expectation.
// ----------------------------------------------------------------------------
module tb_sorted_record_table;

    import srt_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 29;
    localparam int DIR_ROWS     = 23;
    localparam logic [5:0] NO_ZERO = 6'd63;

    typedef struct packed {
        logic             set_limit;
        logic [CNT_W-1:0] limit;
        logic [1:0]       op;
        logic [31:0]      key;
        logic [7:0]       age;
        logic [7:0]       fill;
        logic [5:0]       zero_at;
        logic             typed;
        logic [2:0]       st;
        logic [CNT_W-1:0] cnt;
    } dir_row_t;

    // Names are filled with one byte value, with a zero byte placed at zero_at.
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        '{1'b0, 5'd0,  OP_LIST,   32'h0000_0000, 8'h00, 8'h00, NO_ZERO, 1'b1, ST_EMPTY,     5'd0},
        '{1'b0, 5'd0,  OP_DELETE, 32'h0000_0005, 8'h00, 8'h00, NO_ZERO, 1'b1, ST_NOT_FOUND, 5'd0},
        '{1'b0, 5'd0,  OP_INSERT, 32'h8000_0000, 8'h00, 8'hFF, NO_ZERO, 1'b1, ST_INSERTED,  5'd1},
        '{1'b0, 5'd0,  OP_INSERT, 32'h7FFF_FFFF, 8'hFF, 8'h41, 6'd20,   1'b1, ST_INSERTED,  5'd2},
        '{1'b0, 5'd0,  OP_INSERT, 32'h0000_0000, 8'h5A, 8'h00, 6'd0,    1'b1, ST_INSERTED,  5'd3},
        '{1'b0, 5'd0,  OP_INSERT, 32'h0000_0000, 8'hA5, 8'h55, 6'd48,   1'b1, ST_INSERTED,  5'd4},
        '{1'b0, 5'd0,  OP_INSERT, 32'hFFFF_FFFF, 8'h01, 8'hAA, 6'd7,    1'b1, ST_INSERTED,  5'd5},
        '{1'b0, 5'd0,  OP_LIST,   32'h0000_0000, 8'h00, 8'h00, NO_ZERO, 1'b0, ST_ENTRY,     5'd0},
        '{1'b0, 5'd0,  OP_DELETE, 32'h0000_0000, 8'h00, 8'h00, NO_ZERO, 1'b1, ST_REMOVED,   5'd4},
        '{1'b0, 5'd0,  OP_DELETE, 32'h0000_3039, 8'h00, 8'h00, NO_ZERO, 1'b1, ST_NOT_FOUND, 5'd4},
        '{1'b0, 5'd0,  OP_DELETE, 32'h8000_0000, 8'h00, 8'h00, NO_ZERO, 1'b1, ST_REMOVED,   5'd3},
        '{1'b0, 5'd0,  OP_LIST,   32'h0000_0000, 8'h00, 8'h00, NO_ZERO, 1'b0, ST_ENTRY,     5'd0},
        '{1'b0, 5'd0,  OP_CLEAR,  32'h0000_0000, 8'h00, 8'h00, NO_ZERO, 1'b1, ST_CLEARED,   5'd0},
        '{1'b0, 5'd0,  OP_LIST,   32'h0000_0000, 8'h00, 8'h00, NO_ZERO, 1'b1, ST_EMPTY,     5'd0},
        '{1'b1, 5'd1,  OP_INSERT, 32'h0000_0007, 8'h11, 8'h7F, NO_ZERO, 1'b1, ST_INSERTED,  5'd1},
        '{1'b0, 5'd0,  OP_INSERT, 32'h0000_0008, 8'h22, 8'h33, NO_ZERO, 1'b1, ST_FULL,      5'd1},
        '{1'b1, 5'd0,  OP_INSERT, 32'h0000_0009, 8'h33, 8'h44, NO_ZERO, 1'b1, ST_FULL,      5'd1},
        '{1'b0, 5'd0,  OP_DELETE, 32'h0000_0007, 8'h00, 8'h00, NO_ZERO, 1'b1, ST_REMOVED,   5'd0},
        '{1'b1, 5'd16, OP_INSERT, 32'h0000_0003, 8'h80, 8'h80, 6'd30,   1'b1, ST_INSERTED,  5'd1},
        '{1'b0, 5'd0,  OP_LIST,   32'h0000_0000, 8'h00, 8'h00, NO_ZERO, 1'b0, ST_ENTRY,     5'd0},
        '{1'b1, 5'd31, OP_INSERT, 32'h0000_0003, 8'h7F, 8'h01, 6'd1,    1'b1, ST_INSERTED,  5'd2},
        '{1'b0, 5'd0,  OP_LIST,   32'h0000_0000, 8'h00, 8'h00, NO_ZERO, 1'b0, ST_ENTRY,     5'd0},
        '{1'b0, 5'd0,  OP_CLEAR,  32'h0000_0000, 8'h00, 8'h00, NO_ZERO, 1'b1, ST_CLEARED,   5'd0}
    };

    localparam logic [CNT_W-1:0] PHASE_LIMIT [PHASES] = '{
        5'd16, 5'd31, 5'd4, 5'd0, 5'd1, 5'd16, 5'd12, 5'd20
    };
    localparam int INSERT_PCT [PHASES] = '{70, 75, 40, 35, 50, 72, 45, 55};
    localparam bit CALM [PHASES]       = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    cmd_t             cmd = '0;
    logic             result_valid;
    result_t          result;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CNT_W-1:0] cfg_data = '0;

    // Local copy of the table contents and its limit.
    rec_t             table_q [CAPACITY];
    int               held = 0;
    logic [CNT_W-1:0] limit_q = RESET_MAX_ENTRIES;

    result_t          step_out [$];
    result_t          pending_results [$];
    int               mismatches = 0;
    int               cycles = 0;

    sorted_record_table DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES)
        begin
            $display("%0t: timeout with %0d results still pending", $time,
                     pending_results.size());
            $display("tb: failure");
            $finish;
        end
    end

    function automatic result_t status_only(logic [2:0] st, logic [CNT_W-1:0] cnt);
        result_t r;
        r             = '0;
        r.status      = st;
        r.entry_count = cnt;
        r.last_result = 1'b1;
        return r;
    endfunction

    function automatic result_t listed_entry(int idx, logic last);
        result_t r;
        r             = '0;
        r.status      = ST_ENTRY;
        r.out_key     = table_q[idx].key;
        r.out_age     = table_q[idx].age;
        r.out_name0   = table_q[idx].name[0];
        r.out_name1   = table_q[idx].name[1];
        r.out_name2   = table_q[idx].name[2];
        r.out_name3   = table_q[idx].name[3];
        r.out_name4   = table_q[idx].name[4];
        r.out_name5   = table_q[idx].name[5];
        r.out_name6   = table_q[idx].name[6];
        r.entry_count = held[CNT_W-1:0];
        r.last_result = last;
        return r;
    endfunction

    // The stored name stops at the first zero byte; everything after it is zero.
    function automatic rec_t stored_record(cmd_t c);
        name_t      raw;
        rec_t       r;
        logic       stopped;
        logic [7:0] ch;
        raw = {c.name_part6, c.name_part5, c.name_part4, c.name_part3,
               c.name_part2, c.name_part1, c.name_part0};
        stopped = 1'b0;
        r.key   = c.record_key;
        r.age   = c.record_age;
        r.name  = '0;
        for (int b = 0; b < 7 * NAME_WORDS; b++)
        begin
            ch = raw[b / 7][8 * (b % 7) +: 8];
            if (ch == 8'h00)
                stopped = 1'b1;
            if (!stopped)
                r.name[b / 7][8 * (b % 7) +: 8] = ch;
        end
        return r;
    endfunction

    // Applies one command to the local table and leaves its results in step_out.
    task automatic apply_command(cmd_t c);
        int cap;
        int pos;
        step_out.delete();
        cap = (limit_q > CAPACITY) ? CAPACITY : int'(limit_q);
        pos = 0;
        case (c.operation)
            OP_INSERT:
            begin
                if (held >= cap)
                    step_out.push_back(status_only(ST_FULL, held[CNT_W-1:0]));
                else
                begin
                    while (pos < held && $signed(table_q[pos].key) < $signed(c.record_key))
                        pos++;
                    for (int i = held; i > pos; i--)
                        table_q[i] = table_q[i - 1];
                    table_q[pos] = stored_record(c);
                    held++;
                    step_out.push_back(status_only(ST_INSERTED, held[CNT_W-1:0]));
                end
            end
            OP_DELETE:
            begin
                while (pos < held && table_q[pos].key != c.record_key)
                    pos++;
                if (pos >= held)
                    step_out.push_back(status_only(ST_NOT_FOUND, held[CNT_W-1:0]));
                else
                begin
                    for (int i = pos; i + 1 < held; i++)
                        table_q[i] = table_q[i + 1];
                    held--;
                    step_out.push_back(status_only(ST_REMOVED, held[CNT_W-1:0]));
                end
            end
            OP_LIST:
            begin
                if (held == 0)
                    step_out.push_back(status_only(ST_EMPTY, 5'd0));
                else
                    for (int i = 0; i < held; i++)
                        step_out.push_back(listed_entry(i, i == held - 1));
            end
            default:
            begin
                held = 0;
                step_out.push_back(status_only(ST_CLEARED, 5'd0));
            end
        endcase
    endtask

    function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && result_valid === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, result);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status",      want.status,      result.status);
                check_field("out_key",     want.out_key,     result.out_key);
                check_field("out_age",     want.out_age,     result.out_age);
                check_field("out_name0",   want.out_name0,   result.out_name0);
                check_field("out_name1",   want.out_name1,   result.out_name1);
                check_field("out_name2",   want.out_name2,   result.out_name2);
                check_field("out_name3",   want.out_name3,   result.out_name3);
                check_field("out_name4",   want.out_name4,   result.out_name4);
                check_field("out_name5",   want.out_name5,   result.out_name5);
                check_field("out_name6",   want.out_name6,   result.out_name6);
                check_field("entry_count", want.entry_count, result.entry_count);
                check_field("last_result", want.last_result, result.last_result);
            end
        end
    end

    // Holds the command until the block takes it; start stays high afterwards.
    task automatic send_command(cmd_t c, logic typed, result_t typed_res);
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        apply_command(c);
        if (typed)
            pending_results.push_back(typed_res);
        else
            foreach (step_out[i])
                pending_results.push_back(step_out[i]);
    endtask

    task automatic idle_cycles(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic wait_drained();
        idle_cycles(1);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(logic [CNT_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        limit_q = value;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [31:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40 && held > 0)
            return table_q[$urandom_range(0, held - 1)].key;
        if (r < 75)
            return $urandom_range(0, 16) - 8;
        if (r < 90)
            return $urandom;
        case ($urandom_range(0, 3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            default: return 32'h0000_0000;
        endcase
    endfunction

    function automatic cmd_t random_command(int insert_pct);
        cmd_t  c;
        name_t nm;
        int    r;
        r = $urandom_range(0, 99);
        if (r < insert_pct)
            c.operation = OP_INSERT;
        else if (r < insert_pct + (100 - insert_pct) / 2)
            c.operation = OP_DELETE;
        else if (r < 98)
            c.operation = OP_LIST;
        else
            c.operation = OP_CLEAR;
        c.record_key = pick_key();
        c.record_age = 8'($urandom_range(0, 255));
        for (int w = 0; w < NAME_WORDS; w++)
        begin
            if ($urandom_range(0, 9) == 0)
                nm[w] = 56'({$urandom, $urandom});
            else
                for (int k = 0; k < 7; k++)
                    nm[w][8 * k +: 8] = ($urandom_range(0, 99) < 4) ? 8'h00
                                                                    : 8'($urandom_range(1, 255));
        end
        {c.name_part6, c.name_part5, c.name_part4, c.name_part3,
         c.name_part2, c.name_part1, c.name_part0} = nm;
        return c;
    endfunction

    function automatic cmd_t row_command(dir_row_t row);
        cmd_t  c;
        name_t nm;
        for (int b = 0; b < 7 * NAME_WORDS; b++)
            nm[b / 7][8 * (b % 7) +: 8] = (b == row.zero_at) ? 8'h00 : row.fill;
        c.operation  = row.op;
        c.record_key = row.key;
        c.record_age = row.age;
        {c.name_part6, c.name_part5, c.name_part4, c.name_part3,
         c.name_part2, c.name_part1, c.name_part0} = nm;
        return c;
    endfunction

    initial
    begin : stimulus
        int gap;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
        begin
            if (DIRECTED[i].set_limit)
                write_limit(DIRECTED[i].limit);
            send_command(row_command(DIRECTED[i]), DIRECTED[i].typed,
                         status_only(DIRECTED[i].st, DIRECTED[i].cnt));
            gap = pick_gap();
            if (gap > 0)
                idle_cycles(gap);
        end

        // Limits change with the table still populated, so some phases start
        // with more records held than the new limit allows.
        for (int p = 0; p < PHASES; p++)
        begin
            write_limit(PHASE_LIMIT[p]);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                send_command(random_command(INSERT_PCT[p]), 1'b0, '0);
                gap = CALM[p] ? 0 : pick_gap();
                if (gap > 0)
                    idle_cycles(gap);
            end
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
